// ----- hw/rtl/ssdm_pkg.sv -----
`timescale 1ns / 1ps

package ssdm_pkg;

    localparam int TICK_BITS_DEF   = 32;
    localparam int TICKET_BITS_DEF = 32;

    localparam logic [31:0] TICKET_CAP_RST = 32'hFFFF_FFFF;

    // register byte addresses
    localparam logic [2:0] ADDR_TICKET_CAP = 3'd0;

    // item functions
    localparam logic [2:0] FN_SUBMIT  = 3'd0;
    localparam logic [2:0] FN_CANCEL  = 3'd1;
    localparam logic [2:0] FN_TAKE    = 3'd2;
    localparam logic [2:0] FN_CLOSE   = 3'd3;
    localparam logic [2:0] FN_SERVICE = 3'd4;
    localparam logic [2:0] FN_RELEASE = 3'd5;

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_CLOSED    = 4'd1;
    localparam logic [3:0] ST_CANCELLED = 4'd2;
    localparam logic [3:0] ST_DEADLINE  = 4'd3;
    localparam logic [3:0] ST_TICKREG   = 4'd4;
    localparam logic [3:0] ST_EXHAUSTED = 4'd5;
    localparam logic [3:0] ST_BUSY      = 4'd6;
    localparam logic [3:0] ST_NOTCUR    = 4'd7;
    localparam logic [3:0] ST_TOOLATE   = 4'd8;
    localparam logic [3:0] ST_EMPTY     = 4'd9;
    localparam logic [3:0] ST_SRCERR    = 4'd10;

    // slot stages
    localparam logic [2:0] SG_IDLE     = 3'd0;
    localparam logic [2:0] SG_PENDING  = 3'd1;
    localparam logic [2:0] SG_ACQUIRED = 3'd2;
    localparam logic [2:0] SG_GRANTED  = 3'd3;
    localparam logic [2:0] SG_READY    = 3'd4;
    localparam logic [2:0] SG_HELD     = 3'd5;
    localparam logic [2:0] SG_CONSUMED = 3'd6;
    localparam logic [2:0] SG_CLOSED   = 3'd7;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now;
        logic [31:0] deadline;
        logic [31:0] ticket_in;
        logic [31:0] request;
        logic        source_ok;
        logic [3:0]  source_code;
    } item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  stage_now;
        logic [31:0] ticket_out;
        logic [3:0]  reply_status;
        logic [3:0]  source_code_out;
        logic [31:0] request_out;
        logic [31:0] submitted_tick;
        logic [31:0] grant_tick;
        logic [31:0] publish_tick;
        logic        lease_granted;
        logic        snapshot_strobe;
        logic        reclaim_strobe;
    } result_t;

    // handshake state passed between the pipeline stages
    typedef struct packed {
        logic item_vld;
        logic step;
    } pipe_ctrl_t;

endpackage

// ----- hw/rtl/ssdm_in_stage.sv -----
`timescale 1ns / 1ps

module ssdm_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssdm_pkg::item_t   in_item,
    input  logic              step,
    output ssdm_pkg::item_t   item,
    output logic              item_vld
);

    logic            vld_reg;
    logic            vld_next;
    ssdm_pkg::item_t item_reg;

    // a held item leaves in the same cycle it is stepped, so the slot refills at once
    assign in_ready = !vld_reg || step;
    assign vld_next = (in_valid && in_ready) || (vld_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item     = item_reg;
    assign item_vld = vld_reg;

endmodule

// ----- hw/rtl/ssdm_core.sv -----
`timescale 1ns / 1ps

module ssdm_core #(
    parameter int TICK_BITS   = ssdm_pkg::TICK_BITS_DEF,
    parameter int TICKET_BITS = ssdm_pkg::TICKET_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ssdm_pkg::pipe_ctrl_t ctrl,
    input  ssdm_pkg::item_t   item,
    input  logic [31:0]       ticket_cap,
    output ssdm_pkg::result_t res
);

    localparam int CMP_W = (TICKET_BITS > 32) ? TICKET_BITS : 32;

    logic [2:0]             stage_reg, stage_next;
    logic                   cancel_reg, cancel_next;
    logic                   closing_reg, closing_next;
    logic                   released_reg, released_next;
    logic [TICK_BITS-1:0]   deadline_reg, deadline_next;
    logic [3:0]             reply_status_reg, reply_status_next;
    logic [3:0]             reply_source_reg, reply_source_next;
    logic [31:0]            request_reg, request_next;
    logic [TICK_BITS-1:0]   submit_tick_reg, submit_tick_next;
    logic [TICK_BITS-1:0]   grant_tick_reg, grant_tick_next;
    logic [TICK_BITS-1:0]   publish_tick_reg, publish_tick_next;
    logic [TICKET_BITS-1:0] ticket_count_reg, ticket_count_next;
    logic [TICK_BITS-1:0]   client_tick_reg, client_tick_next;
    logic                   client_seen_reg, client_seen_next;
    logic [TICK_BITS-1:0]   owner_tick_reg, owner_tick_next;
    logic                   owner_seen_reg, owner_seen_next;

    logic [TICK_BITS-1:0]   now_t;
    logic [TICK_BITS-1:0]   dl_t;
    logic [TICKET_BITS-1:0] tk;
    logic [TICKET_BITS-1:0] count_inc;
    logic                   tk_bad;
    logic                   at_max;
    logic                   cli_ok;
    logic                   own_ok;
    logic [3:0]             gate;
    logic [3:0]             take_st;

    assign now_t     = TICK_BITS'(item.now);
    assign dl_t      = TICK_BITS'(item.deadline);
    assign tk        = TICKET_BITS'(item.ticket_in);
    assign count_inc = ticket_count_reg + TICKET_BITS'(1);
    assign tk_bad    = (tk == '0) || (tk != ticket_count_reg);
    assign at_max    = CMP_W'(ticket_count_reg) == CMP_W'(ticket_cap);
    assign cli_ok    = !client_seen_reg || (now_t >= client_tick_reg);
    assign own_ok    = !owner_seen_reg || (now_t >= owner_tick_reg);
    assign take_st   = (gate != ssdm_pkg::ST_OK) ? gate : reply_status_reg;

    always_comb
    begin
        if (closing_reg)
        begin
            gate = ssdm_pkg::ST_CLOSED;
        end
        else if (cancel_reg)
        begin
            gate = ssdm_pkg::ST_CANCELLED;
        end
        else if (now_t >= deadline_reg)
        begin
            gate = ssdm_pkg::ST_DEADLINE;
        end
        else
        begin
            gate = ssdm_pkg::ST_OK;
        end
    end

    always_comb
    begin
        stage_next        = stage_reg;
        cancel_next       = cancel_reg;
        closing_next      = closing_reg;
        released_next     = released_reg;
        deadline_next     = deadline_reg;
        reply_status_next = reply_status_reg;
        reply_source_next = reply_source_reg;
        request_next      = request_reg;
        submit_tick_next  = submit_tick_reg;
        grant_tick_next   = grant_tick_reg;
        publish_tick_next = publish_tick_reg;
        ticket_count_next = ticket_count_reg;
        client_tick_next  = client_tick_reg;
        client_seen_next  = client_seen_reg;
        owner_tick_next   = owner_tick_reg;
        owner_seen_next   = owner_seen_reg;
        res               = '0;
        res.status        = ssdm_pkg::ST_OK;

        unique case (item.func)
            ssdm_pkg::FN_SUBMIT:
            begin
                if (closing_reg)
                begin
                    res.status = ssdm_pkg::ST_CLOSED;
                end
                else if (!cli_ok)
                begin
                    res.status = ssdm_pkg::ST_TICKREG;
                end
                else
                begin
                    // tick is recorded even if a later check fails
                    client_seen_next = 1'b1;
                    client_tick_next = now_t;
                    if (now_t >= dl_t)
                    begin
                        res.status = ssdm_pkg::ST_DEADLINE;
                    end
                    else if (at_max)
                    begin
                        res.status = ssdm_pkg::ST_EXHAUSTED;
                    end
                    else if (stage_reg != ssdm_pkg::SG_IDLE)
                    begin
                        res.status = (stage_reg == ssdm_pkg::SG_CLOSED) ?
                                     ssdm_pkg::ST_CLOSED : ssdm_pkg::ST_BUSY;
                    end
                    else
                    begin
                        ticket_count_next = count_inc;
                        cancel_next       = 1'b0;
                        released_next     = 1'b0;
                        deadline_next     = dl_t;
                        reply_status_next = ssdm_pkg::ST_OK;
                        reply_source_next = 4'd0;
                        request_next      = item.request;
                        submit_tick_next  = now_t;
                        grant_tick_next   = '0;
                        publish_tick_next = '0;
                        stage_next        = ssdm_pkg::SG_PENDING;
                        res.ticket_out    = 32'(count_inc);
                    end
                end
            end
            ssdm_pkg::FN_CANCEL:
            begin
                if (tk_bad)
                begin
                    res.status = ssdm_pkg::ST_NOTCUR;
                end
                else if (stage_reg >= ssdm_pkg::SG_PENDING && stage_reg <= ssdm_pkg::SG_READY)
                begin
                    cancel_next = 1'b1;
                end
                else
                begin
                    res.status = ssdm_pkg::ST_TOOLATE;
                end
            end
            ssdm_pkg::FN_TAKE:
            begin
                if (tk_bad)
                begin
                    res.status = ssdm_pkg::ST_NOTCUR;
                end
                else if (!cli_ok)
                begin
                    res.status = ssdm_pkg::ST_TICKREG;
                end
                else
                begin
                    client_seen_next = 1'b1;
                    client_tick_next = now_t;
                    if (stage_reg != ssdm_pkg::SG_READY)
                    begin
                        res.status = (stage_reg == ssdm_pkg::SG_CLOSED) ?
                                     ssdm_pkg::ST_CLOSED : ssdm_pkg::ST_EMPTY;
                    end
                    else if (now_t < publish_tick_reg)
                    begin
                        res.status = ssdm_pkg::ST_TICKREG;
                    end
                    else
                    begin
                        if (gate != ssdm_pkg::ST_OK)
                        begin
                            reply_status_next = gate;
                            reply_source_next = 4'd0;
                        end
                        else
                        begin
                            res.source_code_out = reply_source_reg;
                        end
                        res.status         = take_st;
                        res.request_out    = request_reg;
                        res.submitted_tick = 32'(submit_tick_reg);
                        res.grant_tick     = 32'(grant_tick_reg);
                        res.publish_tick   = 32'(publish_tick_reg);
                        if (take_st == ssdm_pkg::ST_OK)
                        begin
                            res.lease_granted = 1'b1;
                            stage_next        = ssdm_pkg::SG_HELD;
                        end
                        else
                        begin
                            stage_next = ssdm_pkg::SG_CONSUMED;
                        end
                    end
                end
                res.reply_status = res.status;
            end
            ssdm_pkg::FN_CLOSE:
            begin
                closing_next = 1'b1;
            end
            ssdm_pkg::FN_SERVICE:
            begin
                if (stage_reg == ssdm_pkg::SG_CLOSED)
                begin
                    res.status = ssdm_pkg::ST_CLOSED;
                end
                else if (!own_ok)
                begin
                    res.status = ssdm_pkg::ST_TICKREG;
                end
                else
                begin
                    owner_seen_next = 1'b1;
                    owner_tick_next = now_t;
                    unique case (stage_reg)
                        ssdm_pkg::SG_IDLE:
                        begin
                            if (closing_reg)
                            begin
                                stage_next = ssdm_pkg::SG_CLOSED;
                                res.status = ssdm_pkg::ST_CLOSED;
                            end
                            else
                            begin
                                res.status = ssdm_pkg::ST_EMPTY;
                            end
                        end
                        ssdm_pkg::SG_PENDING:
                        begin
                            if (now_t < submit_tick_reg)
                            begin
                                res.status = ssdm_pkg::ST_TICKREG;
                            end
                            else
                            begin
                                reply_status_next = gate;
                                stage_next        = ssdm_pkg::SG_ACQUIRED;
                            end
                        end
                        ssdm_pkg::SG_ACQUIRED:
                        begin
                            grant_tick_next = now_t;
                            if (gate != ssdm_pkg::ST_OK)
                            begin
                                reply_status_next = gate;
                                reply_source_next = 4'd0;
                            end
                            else
                            begin
                                res.snapshot_strobe = 1'b1;
                                res.request_out     = request_reg;
                                reply_source_next   = item.source_code;
                                reply_status_next   = item.source_ok ?
                                                      ssdm_pkg::ST_OK : ssdm_pkg::ST_SRCERR;
                            end
                            stage_next = ssdm_pkg::SG_GRANTED;
                        end
                        ssdm_pkg::SG_GRANTED:
                        begin
                            if (gate != ssdm_pkg::ST_OK)
                            begin
                                reply_status_next  = gate;
                                reply_source_next  = 4'd0;
                                res.reclaim_strobe = 1'b1;
                            end
                            publish_tick_next = now_t;
                            stage_next        = ssdm_pkg::SG_READY;
                        end
                        ssdm_pkg::SG_HELD,
                        ssdm_pkg::SG_CONSUMED:
                        begin
                            if (stage_reg == ssdm_pkg::SG_HELD && closing_reg)
                            begin
                                res.reclaim_strobe = released_reg;
                                stage_next         = ssdm_pkg::SG_CLOSED;
                                res.status         = ssdm_pkg::ST_CLOSED;
                            end
                            else if (stage_reg == ssdm_pkg::SG_HELD && !released_reg)
                            begin
                                res.status = ssdm_pkg::ST_BUSY;
                            end
                            else
                            begin
                                // reply is done with: free storage and empty the slot
                                res.reclaim_strobe = 1'b1;
                                reply_status_next  = ssdm_pkg::ST_OK;
                                reply_source_next  = 4'd0;
                                request_next       = 32'd0;
                                submit_tick_next   = '0;
                                grant_tick_next    = '0;
                                publish_tick_next  = '0;
                                stage_next = closing_reg ? ssdm_pkg::SG_CLOSED : ssdm_pkg::SG_IDLE;
                                res.status = closing_reg ? ssdm_pkg::ST_CLOSED : ssdm_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            // ready waits for the client's take
                            res.status = ssdm_pkg::ST_BUSY;
                        end
                    endcase
                end
            end
            ssdm_pkg::FN_RELEASE:
            begin
                if (stage_reg == ssdm_pkg::SG_HELD)
                begin
                    released_next = 1'b1;
                end
                else
                begin
                    res.status = ssdm_pkg::ST_NOTCUR;
                end
            end
            default:
            begin
                res.status = ssdm_pkg::ST_BUSY;
            end
        endcase

        res.stage_now = stage_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg        <= ssdm_pkg::SG_IDLE;
            cancel_reg       <= 1'b0;
            closing_reg      <= 1'b0;
            released_reg     <= 1'b0;
            deadline_reg     <= '0;
            reply_status_reg <= ssdm_pkg::ST_OK;
            reply_source_reg <= 4'd0;
            request_reg      <= 32'd0;
            submit_tick_reg  <= '0;
            grant_tick_reg   <= '0;
            publish_tick_reg <= '0;
            ticket_count_reg <= '0;
            client_tick_reg  <= '0;
            client_seen_reg  <= 1'b0;
            owner_tick_reg   <= '0;
            owner_seen_reg   <= 1'b0;
        end
        else if (ctrl.step && ctrl.item_vld)
        begin
            stage_reg        <= stage_next;
            cancel_reg       <= cancel_next;
            closing_reg      <= closing_next;
            released_reg     <= released_next;
            deadline_reg     <= deadline_next;
            reply_status_reg <= reply_status_next;
            reply_source_reg <= reply_source_next;
            request_reg      <= request_next;
            submit_tick_reg  <= submit_tick_next;
            grant_tick_reg   <= grant_tick_next;
            publish_tick_reg <= publish_tick_next;
            ticket_count_reg <= ticket_count_next;
            client_tick_reg  <= client_tick_next;
            client_seen_reg  <= client_seen_next;
            owner_tick_reg   <= owner_tick_next;
            owner_seen_reg   <= owner_seen_next;
        end
    end

endmodule

// ----- hw/rtl/ssdm_out_stage.sv -----
`timescale 1ns / 1ps

module ssdm_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ssdm_pkg::result_t res,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output ssdm_pkg::result_t out_res
);

    logic              vld_reg;
    logic              vld_next;
    ssdm_pkg::result_t res_reg;

    // a new beat may land in the same cycle the old one is taken
    assign room     = !vld_reg || out_ready;
    assign vld_next = load || (vld_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

endmodule

// ----- hw/rtl/single_slot_deadline_mailbox_top.sv -----
`timescale 1ns / 1ps

// channel   | handshake          | beat contents
// ----------+--------------------+-------------------------------------------------
// input     | in_valid/in_ready  | func, now, deadline, ticket_in, request, source_*
// result    | out_valid/out_ready| status, stage_now, ticket_out, reply/stored fields
// register  | apb psel..pready   | ticket_cap at byte address 0
//
// one item per cycle sustained while the result side is not stalled; each item passes
// through the input register and then the result register.
// the slot state is updated by the step logic as the item moves into the result
// register. a stalled result stops the step; the input register then holds one
// more item. reset clears the slot state and the ticket cap returns to all ones.
module single_slot_deadline_mailbox_top #(
    parameter int TICK_BITS   = ssdm_pkg::TICK_BITS_DEF,
    parameter int TICKET_BITS = ssdm_pkg::TICKET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [31:0] now,
    input  logic [31:0] deadline,
    input  logic [31:0] ticket_in,
    input  logic [31:0] request,
    input  logic        source_ok,
    input  logic [3:0]  source_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [2:0]  stage_now,
    output logic [31:0] ticket_out,
    output logic [3:0]  reply_status,
    output logic [3:0]  source_code_out,
    output logic [31:0] request_out,
    output logic [31:0] submitted_tick,
    output logic [31:0] grant_tick,
    output logic [31:0] publish_tick,
    output logic        lease_granted,
    output logic        snapshot_strobe,
    output logic        reclaim_strobe
);

    logic [31:0]          ticket_cap_reg;
    logic                 reg_wr;
    ssdm_pkg::item_t      in_item;
    ssdm_pkg::item_t      item;
    ssdm_pkg::result_t    res;
    ssdm_pkg::result_t    out_res;
    ssdm_pkg::pipe_ctrl_t ctrl;
    logic                 item_vld;
    logic                 step;
    logic                 room;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[2] == ssdm_pkg::ADDR_TICKET_CAP[2]);
    assign prdata = (paddr[2] == ssdm_pkg::ADDR_TICKET_CAP[2]) ? ticket_cap_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticket_cap_reg <= ssdm_pkg::TICKET_CAP_RST;
        end
        else if (reg_wr)
        begin
            ticket_cap_reg <= pwdata;
        end
    end

    assign in_item.func        = func;
    assign in_item.now         = now;
    assign in_item.deadline    = deadline;
    assign in_item.ticket_in   = ticket_in;
    assign in_item.request     = request;
    assign in_item.source_ok   = source_ok;
    assign in_item.source_code = source_code;

    assign step = item_vld && room;
    assign ctrl = {item_vld, step};

    ssdm_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .step     (step),
        .item     (item),
        .item_vld (item_vld)
    );

    ssdm_core #(
        .TICK_BITS   (TICK_BITS),
        .TICKET_BITS (TICKET_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .item       (item),
        .ticket_cap (ticket_cap_reg),
        .res        (res)
    );

    ssdm_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status          = out_res.status;
    assign stage_now       = out_res.stage_now;
    assign ticket_out      = out_res.ticket_out;
    assign reply_status    = out_res.reply_status;
    assign source_code_out = out_res.source_code_out;
    assign request_out     = out_res.request_out;
    assign submitted_tick  = out_res.submitted_tick;
    assign grant_tick      = out_res.grant_tick;
    assign publish_tick    = out_res.publish_tick;
    assign lease_granted   = out_res.lease_granted;
    assign snapshot_strobe = out_res.snapshot_strobe;
    assign reclaim_strobe  = out_res.reclaim_strobe;

endmodule

// ----- hw/rtl/ssdm_checker.sv -----
`timescale 1ns / 1ps

module ssdm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  status,
    input logic [2:0]  stage_now,
    input logic [31:0] ticket_out,
    input logic [3:0]  reply_status,
    input logic        lease_granted,
    input logic        snapshot_strobe,
    input logic        reclaim_strobe
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(stage_now))
        else $error("result beat changed while stalled");

    // a lease hand-over only comes from a clean take
    a_lease: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lease_granted |-> status == ssdm_pkg::ST_OK
            && reply_status == ssdm_pkg::ST_OK && stage_now == ssdm_pkg::SG_HELD)
        else $error("lease granted without a good take");

    // snapshot request moves the slot to granted
    a_snap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && snapshot_strobe |-> status == ssdm_pkg::ST_OK
            && stage_now == ssdm_pkg::SG_GRANTED && !reclaim_strobe)
        else $error("snapshot strobe outside grant step");

    // a ticket is only issued by a submit that lands in pending
    a_ticket: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ticket_out != 32'd0 |-> status == ssdm_pkg::ST_OK
            && stage_now == ssdm_pkg::SG_PENDING)
        else $error("ticket issued without entering pending");

endmodule

bind single_slot_deadline_mailbox_top ssdm_checker u_ssdm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .stage_now       (stage_now),
    .ticket_out      (ticket_out),
    .reply_status    (reply_status),
    .lease_granted   (lease_granted),
    .snapshot_strobe (snapshot_strobe),
    .reclaim_strobe  (reclaim_strobe)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // function codes outside the defined set
    localparam logic [2:0] FN_UNDEF_LO = 3'd6;
    localparam logic [2:0] FN_UNDEF_HI = 3'd7;

    typedef struct {
        ssdm_pkg::item_t body;
        bit              live_ticket;
        logic [31:0]     ticket_skew;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  func = '0;
    logic [31:0] now = '0;
    logic [31:0] deadline = '0;
    logic [31:0] ticket_in = '0;
    logic [31:0] request = '0;
    logic        source_ok = 1'b0;
    logic [3:0]  source_code = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  status;
    logic [2:0]  stage_now;
    logic [31:0] ticket_out;
    logic [3:0]  reply_status;
    logic [3:0]  source_code_out;
    logic [31:0] request_out;
    logic [31:0] submitted_tick;
    logic [31:0] grant_tick;
    logic [31:0] publish_tick;
    logic        lease_granted;
    logic        snapshot_strobe;
    logic        reclaim_strobe;

    single_slot_deadline_mailbox_top uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mailbox state as the block should hold it
    logic [31:0] ticket_limit = 32'hFFFF_FFFF;
    logic [2:0]  slot_stage = ssdm_pkg::SG_IDLE;
    bit          cancel_f, closing_f, released_f;
    logic [31:0] dl_q = '0, req_q = '0, sub_tick_q = '0, grant_tick_q = '0, pub_tick_q = '0;
    logic [3:0]  rep_status_q = ssdm_pkg::ST_OK;
    logic [3:0]  rep_source_q = '0;
    logic [31:0] ticket_cnt = '0;
    logic [31:0] client_last = '0, owner_last = '0;
    bit          client_seen, owner_seen;

    stim_t             queued_requests[$];
    ssdm_pkg::result_t expected_replies[$];
    stim_t             next_req;
    ssdm_pkg::item_t   cur_item;
    int          items_taken = 0;
    int          queued_total = 0;
    int          mismatch_count = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    logic [31:0] tick_base = '0;
    logic        hold_arm = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;

    function automatic logic [3:0] gate_status(logic [31:0] t);
        if (closing_f)
            return ssdm_pkg::ST_CLOSED;
        if (cancel_f)
            return ssdm_pkg::ST_CANCELLED;
        if (t >= dl_q)
            return ssdm_pkg::ST_DEADLINE;
        return ssdm_pkg::ST_OK;
    endfunction

    function automatic void clear_reply();
        rep_status_q = ssdm_pkg::ST_OK;
        rep_source_q = '0;
        req_q = '0;
        sub_tick_q = '0;
        grant_tick_q = '0;
        pub_tick_q = '0;
    endfunction

    function automatic void drop_reply(logic [3:0] st);
        rep_status_q = st;
        rep_source_q = '0;
    endfunction

    // the tick is recorded as soon as the check passes
    function automatic bit client_tick_pass(logic [31:0] t);
        if (client_seen && t < client_last)
            return 1'b0;
        client_seen = 1'b1;
        client_last = t;
        return 1'b1;
    endfunction

    function automatic bit owner_tick_pass(logic [31:0] t);
        if (owner_seen && t < owner_last)
            return 1'b0;
        owner_seen = 1'b1;
        owner_last = t;
        return 1'b1;
    endfunction

    function automatic ssdm_pkg::result_t mailbox_step(ssdm_pkg::item_t it);
        ssdm_pkg::result_t r;
        logic [3:0]        st;
        logic [3:0]        g;
        bit                stale;
        r = '0;
        st = ssdm_pkg::ST_OK;
        stale = (it.ticket_in == 0) || (it.ticket_in != ticket_cnt);
        case (it.func)
            ssdm_pkg::FN_SUBMIT:
            begin
                if (closing_f)
                    st = ssdm_pkg::ST_CLOSED;
                else if (!client_tick_pass(it.now))
                    st = ssdm_pkg::ST_TICKREG;
                else if (it.now >= it.deadline)
                    st = ssdm_pkg::ST_DEADLINE;
                else if (ticket_cnt == ticket_limit)
                    st = ssdm_pkg::ST_EXHAUSTED;
                else if (slot_stage != ssdm_pkg::SG_IDLE)
                    st = (slot_stage == ssdm_pkg::SG_CLOSED) ? ssdm_pkg::ST_CLOSED :
                                                               ssdm_pkg::ST_BUSY;
                else
                begin
                    ticket_cnt = ticket_cnt + 32'd1;
                    cancel_f = 1'b0;
                    released_f = 1'b0;
                    dl_q = it.deadline;
                    clear_reply();
                    req_q = it.request;
                    sub_tick_q = it.now;
                    slot_stage = ssdm_pkg::SG_PENDING;
                    r.ticket_out = ticket_cnt;
                end
            end
            ssdm_pkg::FN_CANCEL:
            begin
                if (stale)
                    st = ssdm_pkg::ST_NOTCUR;
                else if (slot_stage >= ssdm_pkg::SG_PENDING && slot_stage <= ssdm_pkg::SG_READY)
                    cancel_f = 1'b1;
                else
                    st = ssdm_pkg::ST_TOOLATE;
            end
            ssdm_pkg::FN_TAKE:
            begin
                if (stale)
                    st = ssdm_pkg::ST_NOTCUR;
                else if (!client_tick_pass(it.now))
                    st = ssdm_pkg::ST_TICKREG;
                else if (slot_stage != ssdm_pkg::SG_READY)
                    st = (slot_stage == ssdm_pkg::SG_CLOSED) ? ssdm_pkg::ST_CLOSED :
                                                               ssdm_pkg::ST_EMPTY;
                else if (it.now < pub_tick_q)
                    st = ssdm_pkg::ST_TICKREG;
                else
                begin
                    g = gate_status(it.now);
                    if (g != ssdm_pkg::ST_OK)
                        drop_reply(g);
                    st = rep_status_q;
                    r.source_code_out = rep_source_q;
                    r.request_out = req_q;
                    r.submitted_tick = sub_tick_q;
                    r.grant_tick = grant_tick_q;
                    r.publish_tick = pub_tick_q;
                    if (st == ssdm_pkg::ST_OK)
                    begin
                        r.lease_granted = 1'b1;
                        slot_stage = ssdm_pkg::SG_HELD;
                    end
                    else
                        slot_stage = ssdm_pkg::SG_CONSUMED;
                end
                r.reply_status = st;
            end
            ssdm_pkg::FN_CLOSE:
                closing_f = 1'b1;
            ssdm_pkg::FN_SERVICE:
            begin
                if (slot_stage == ssdm_pkg::SG_CLOSED)
                    st = ssdm_pkg::ST_CLOSED;
                else if (!owner_tick_pass(it.now))
                    st = ssdm_pkg::ST_TICKREG;
                else
                begin
                    case (slot_stage)
                        ssdm_pkg::SG_IDLE:
                        begin
                            if (closing_f)
                            begin
                                slot_stage = ssdm_pkg::SG_CLOSED;
                                st = ssdm_pkg::ST_CLOSED;
                            end
                            else
                                st = ssdm_pkg::ST_EMPTY;
                        end
                        ssdm_pkg::SG_PENDING:
                        begin
                            if (it.now < sub_tick_q)
                                st = ssdm_pkg::ST_TICKREG;
                            else
                            begin
                                rep_status_q = gate_status(it.now);
                                slot_stage = ssdm_pkg::SG_ACQUIRED;
                            end
                        end
                        ssdm_pkg::SG_ACQUIRED:
                        begin
                            grant_tick_q = it.now;
                            g = gate_status(it.now);
                            if (g != ssdm_pkg::ST_OK)
                                drop_reply(g);
                            else
                            begin
                                r.snapshot_strobe = 1'b1;
                                r.request_out = req_q;
                                rep_source_q = it.source_code;
                                rep_status_q = it.source_ok ? ssdm_pkg::ST_OK :
                                                              ssdm_pkg::ST_SRCERR;
                            end
                            slot_stage = ssdm_pkg::SG_GRANTED;
                        end
                        ssdm_pkg::SG_GRANTED:
                        begin
                            g = gate_status(it.now);
                            if (g != ssdm_pkg::ST_OK)
                            begin
                                drop_reply(g);
                                r.reclaim_strobe = 1'b1;
                            end
                            pub_tick_q = it.now;
                            slot_stage = ssdm_pkg::SG_READY;
                        end
                        ssdm_pkg::SG_HELD, ssdm_pkg::SG_CONSUMED:
                        begin
                            if (slot_stage == ssdm_pkg::SG_HELD && closing_f)
                            begin
                                r.reclaim_strobe = released_f;
                                slot_stage = ssdm_pkg::SG_CLOSED;
                                st = ssdm_pkg::ST_CLOSED;
                            end
                            else if (slot_stage == ssdm_pkg::SG_HELD && !released_f)
                                st = ssdm_pkg::ST_BUSY;
                            else
                            begin
                                r.reclaim_strobe = 1'b1;
                                clear_reply();
                                slot_stage = closing_f ? ssdm_pkg::SG_CLOSED :
                                                         ssdm_pkg::SG_IDLE;
                                st = closing_f ? ssdm_pkg::ST_CLOSED : ssdm_pkg::ST_OK;
                            end
                        end
                        default:
                            st = ssdm_pkg::ST_BUSY;
                    endcase
                end
            end
            ssdm_pkg::FN_RELEASE:
            begin
                if (slot_stage == ssdm_pkg::SG_HELD)
                    released_f = 1'b1;
                else
                    st = ssdm_pkg::ST_NOTCUR;
            end
            default:
                st = ssdm_pkg::ST_BUSY;
        endcase
        r.status = st;
        r.stage_now = slot_stage;
        return r;
    endfunction

    // input side: present queued items, predict each accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_replies.push_back(mailbox_step(cur_item));
                items_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    next_req = queued_requests.pop_front();
                    cur_item = next_req.body;
                    // ticket resolved against the slot as all earlier beats left it
                    if (next_req.live_ticket)
                        cur_item.ticket_in = ticket_cnt + next_req.ticket_skew;
                    func <= cur_item.func;
                    now <= cur_item.now;
                    deadline <= cur_item.deadline;
                    ticket_in <= cur_item.ticket_in;
                    request <= cur_item.request;
                    source_ok <= cur_item.source_ok;
                    source_code <= cur_item.source_code;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            mismatch_count++;
        end
    endfunction

    // result side
    always @(posedge clk)
    begin
        ssdm_pkg::result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("result beat with no reply expected");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("stage_now", 32'(want.stage_now), 32'(stage_now));
                    check_field("ticket_out", want.ticket_out, ticket_out);
                    check_field("reply_status", 32'(want.reply_status), 32'(reply_status));
                    check_field("source_code_out", 32'(want.source_code_out),
                                32'(source_code_out));
                    check_field("request_out", want.request_out, request_out);
                    check_field("submitted_tick", want.submitted_tick, submitted_tick);
                    check_field("grant_tick", want.grant_tick, grant_tick);
                    check_field("publish_tick", want.publish_tick, publish_tick);
                    check_field("lease_granted", 32'(want.lease_granted), 32'(lease_granted));
                    check_field("snapshot_strobe", 32'(want.snapshot_strobe),
                                32'(snapshot_strobe));
                    check_field("reclaim_strobe", 32'(want.reclaim_strobe),
                                32'(reclaim_strobe));
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // one long receiver hold-off once armed
    always @(posedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    function automatic logic [31:0] draw_tick();
        logic [31:0] stride;
        stride = $urandom_range(0, 3);
        tick_base = (tick_base > 32'hFFFF_FFFF - stride) ? 32'hFFFF_FFFF : tick_base + stride;
        // an occasional step back in time
        if ($urandom_range(0, 99) < 3 && tick_base > 8)
            return tick_base - $urandom_range(1, 8);
        return tick_base;
    endfunction

    function automatic stim_t make_item(logic [2:0] fn);
        stim_t       s;
        logic [31:0] t;
        logic [31:0] margin;
        t = draw_tick();
        margin = ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom_range(1, 60));
        s.body.func = fn;
        s.body.now = t;
        s.body.deadline = (t > 32'hFFFF_FFFF - margin) ? 32'hFFFF_FFFF : t + margin;
        s.body.ticket_in = '0;
        s.body.request = $urandom;
        s.body.source_ok = ($urandom_range(0, 4) != 0);
        s.body.source_code = 4'($urandom_range(0, 15));
        s.live_ticket = 1'b1;
        s.ticket_skew = ($urandom_range(0, 19) == 0) ? 32'd1 : 32'd0;
        return s;
    endfunction

    function automatic void enqueue(stim_t s);
        queued_requests.push_back(s);
        if (s.body.func <= ssdm_pkg::FN_RELEASE)
            queued_total++;
    endfunction

    function automatic void queue_noise();
        stim_t      s;
        logic [2:0] fn;
        fn = 3'($urandom_range(0, 7));
        // closing is one-way, so it only comes where placed on purpose
        if (fn == ssdm_pkg::FN_CLOSE)
            fn = FN_UNDEF_LO;
        s = make_item(fn);
        if (fn == ssdm_pkg::FN_CANCEL || fn == ssdm_pkg::FN_RELEASE || fn > ssdm_pkg::FN_RELEASE)
        begin
            // these never look at the tick, so any value is safe
            s.body.now = $urandom;
            s.body.deadline = $urandom;
        end
        if ($urandom_range(0, 1) == 0)
        begin
            s.live_ticket = 1'b0;
            case ($urandom_range(0, 2))
                0: s.body.ticket_in = '0;
                1: s.body.ticket_in = '1;
                default: s.body.ticket_in = $urandom;
            endcase
        end
        enqueue(s);
    endfunction

    function automatic void queue_session();
        logic [2:0] steps [7];
        int         cancel_at;
        int         roll;
        steps = '{ssdm_pkg::FN_SUBMIT, ssdm_pkg::FN_SERVICE, ssdm_pkg::FN_SERVICE,
                  ssdm_pkg::FN_SERVICE, ssdm_pkg::FN_TAKE, ssdm_pkg::FN_RELEASE,
                  ssdm_pkg::FN_SERVICE};
        cancel_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : -1;
        foreach (steps[k])
        begin
            if (k == cancel_at)
                enqueue(make_item(ssdm_pkg::FN_CANCEL));
            roll = $urandom_range(0, 99);
            if (roll >= 4)
                enqueue(make_item(steps[k]));
            if (roll >= 96)
                enqueue(make_item(steps[k]));
        end
    endfunction

    function automatic void queue_phase(int count);
        int start;
        start = queued_total;
        while (queued_total - start < count)
        begin
            if ($urandom_range(0, 99) < 15)
                queue_noise();
            else
                queue_session();
        end
    endfunction

    function automatic stim_t fixed_item(logic [2:0] fn, logic [31:0] t, logic [31:0] dl,
                                          bit live);
        stim_t s;
        s = make_item(fn);
        s.body.now = t;
        s.body.deadline = dl;
        s.live_ticket = live;
        s.ticket_skew = '0;
        s.body.source_ok = 1'b1;
        return s;
    endfunction

    task automatic settle();
        do
            @(posedge clk);
        while (queued_requests.size() != 0 || in_valid || expected_replies.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_ticket_cap(logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ssdm_pkg::ADDR_TICKET_CAP;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        ticket_limit = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== value)
        begin
            $error("ticket_cap: expected %0h, got %0h", value, prdata);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        stim_t s;
        int    mark;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        send_gap_pct = 22;
        recv_stall_pct = 55;

        // a limit of one ticket: the second good submit runs out
        set_ticket_cap(32'd1);
        enqueue(fixed_item(ssdm_pkg::FN_SERVICE, 32'd0, 32'd5, 1'b0));
        enqueue(fixed_item(ssdm_pkg::FN_TAKE, 32'd0, 32'd5, 1'b0));
        s = fixed_item(ssdm_pkg::FN_CANCEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        s.body.ticket_in = '1;
        enqueue(s);
        enqueue(fixed_item(ssdm_pkg::FN_RELEASE, 32'd0, 32'd0, 1'b0));
        enqueue(fixed_item(FN_UNDEF_HI, 32'hFFFF_FFFF, 32'd0, 1'b0));
        enqueue(fixed_item(ssdm_pkg::FN_SUBMIT, 32'd0, 32'd0, 1'b0));
        s = fixed_item(ssdm_pkg::FN_SUBMIT, 32'd1, 32'hFFFF_FFFF, 1'b0);
        s.body.request = '1;
        enqueue(s);
        enqueue(fixed_item(ssdm_pkg::FN_SUBMIT, 32'd2, 32'hFFFF_FFFF, 1'b0));
        enqueue(fixed_item(ssdm_pkg::FN_TAKE, 32'd3, 32'd0, 1'b1));
        enqueue(fixed_item(ssdm_pkg::FN_SERVICE, 32'd4, 32'd0, 1'b0));
        // snapshot reports a bad lease
        s = fixed_item(ssdm_pkg::FN_SERVICE, 32'd5, 32'd0, 1'b0);
        s.body.source_ok = 1'b0;
        s.body.source_code = 4'hF;
        enqueue(s);
        enqueue(fixed_item(ssdm_pkg::FN_SERVICE, 32'd6, 32'd0, 1'b0));
        enqueue(fixed_item(ssdm_pkg::FN_TAKE, 32'd7, 32'd0, 1'b1));
        enqueue(fixed_item(ssdm_pkg::FN_SERVICE, 32'd8, 32'd0, 1'b0));
        settle();

        // cancelled request runs to the end, then a late cancel
        set_ticket_cap(32'hFFFF_FFFF);
        enqueue(fixed_item(ssdm_pkg::FN_SUBMIT, 32'd10, 32'hFFFF_FFFF, 1'b0));
        enqueue(fixed_item(ssdm_pkg::FN_CANCEL, 32'd11, 32'd0, 1'b1));
        enqueue(fixed_item(ssdm_pkg::FN_SERVICE, 32'd12, 32'd0, 1'b0));
        enqueue(fixed_item(ssdm_pkg::FN_SERVICE, 32'd13, 32'd0, 1'b0));
        enqueue(fixed_item(ssdm_pkg::FN_SERVICE, 32'd14, 32'd0, 1'b0));
        enqueue(fixed_item(ssdm_pkg::FN_TAKE, 32'd15, 32'd0, 1'b1));
        enqueue(fixed_item(ssdm_pkg::FN_CANCEL, 32'd16, 32'd0, 1'b1));
        enqueue(fixed_item(ssdm_pkg::FN_SERVICE, 32'd17, 32'd0, 1'b0));
        tick_base = 32'd20;
        settle();

        set_ticket_cap({1'b1, 31'($urandom)});
        queue_phase(500);
        settle();

        send_gap_pct = 55;
        recv_stall_pct = 22;
        set_ticket_cap(ticket_cnt + 32'($urandom_range(20, 40)));
        queue_phase(450);
        settle();

        // limit below the counter; receiver stops for a while so the block backs up
        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_ticket_cap((ticket_cnt > 1) ? 32'($urandom_range(1, ticket_cnt - 1)) : 32'd1);
        mark = items_taken;
        queue_phase(450);
        while (items_taken < mark + 40)
            @(posedge clk);
        hold_arm <= 1'b1;
        settle();

        // top of the tick range, then the mailbox is closed for good
        set_ticket_cap(32'hFFFF_FFFF);
        tick_base = 32'hFFFF_F000;
        queue_phase(200);
        queue_session();
        enqueue(make_item(ssdm_pkg::FN_CLOSE));
        queue_phase(150);
        settle();
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
